/* sv/hcu_pkg.sv */
// Package for the horizontal 2x chroma upsampler: widths, register indexes,
// control struct and the coefficient rows of the bicubic and Lanczos-3 kernels.
// Used by every other file of the block; depends on nothing.
package hcu_pkg;

  localparam int MaxWidthDef = 4096;
  localparam int NumTaps     = 6;
  localparam int CodeW       = 5;
  localparam int RemW        = 3;
  localparam int CfgIdxW     = 2;
  localparam int LineW       = 13;
  localparam int CoefW       = 9;
  localparam int ProdW       = 18;
  localparam int SumW        = 20;

  localparam logic [CfgIdxW-1:0] REG_KERNEL_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LINE_WIDTH  = 2'd1;

  localparam logic [LineW-1:0] LINE_WIDTH_RST = 13'd8;
  localparam logic [LineW-1:0] LINE_WIDTH_MIN = 13'd6;

  // Output codes. Each burst walks through consecutive codes.
  localparam logic [CodeW-1:0] BC_E0 = 5'd0;
  localparam logic [CodeW-1:0] BC_E1 = 5'd1;
  localparam logic [CodeW-1:0] BC_E2 = 5'd2;
  localparam logic [CodeW-1:0] BC_M0 = 5'd3;
  localparam logic [CodeW-1:0] BC_M1 = 5'd4;
  localparam logic [CodeW-1:0] BC_T0 = 5'd5;
  localparam logic [CodeW-1:0] BC_T1 = 5'd6;
  localparam logic [CodeW-1:0] BC_T2 = 5'd7;
  localparam logic [CodeW-1:0] LZ_E0 = 5'd8;
  localparam logic [CodeW-1:0] LZ_E1 = 5'd9;
  localparam logic [CodeW-1:0] LZ_E2 = 5'd10;
  localparam logic [CodeW-1:0] LZ_E3 = 5'd11;
  localparam logic [CodeW-1:0] LZ_E4 = 5'd12;
  localparam logic [CodeW-1:0] LZ_M0 = 5'd13;
  localparam logic [CodeW-1:0] LZ_M1 = 5'd14;
  localparam logic [CodeW-1:0] LZ_T0 = 5'd15;
  localparam logic [CodeW-1:0] LZ_T1 = 5'd16;
  localparam logic [CodeW-1:0] LZ_T2 = 5'd17;
  localparam logic [CodeW-1:0] LZ_T3 = 5'd18;
  localparam logic [CodeW-1:0] LZ_T4 = 5'd19;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef coef_t [0:NumTaps-1] coef_row_t;   // [0] oldest tap, [5] newest

  typedef struct packed {
    logic             active;
    logic [CodeW-1:0] code;
    logic             last_of_burst;
    logic             line_done;
  } seq_t;

  function automatic coef_row_t coef_row(input logic [CodeW-1:0] code);
    int        c [NumTaps];
    coef_row_t row;
    case (code)
      BC_E0:   c = '{0, 0, 0, 0, 139, -11};
      BC_E1:   c = '{0, 0, 0, 104, 27, -3};
      BC_E2:   c = '{0, 0, 0, 28, 109, -9};
      BC_M0:   c = '{0, 0, -9, 111, 29, -3};
      BC_M1:   c = '{0, 0, -3, 29, 111, -9};
      BC_T0:   c = '{0, 0, 0, -9, 109, 28};
      BC_T1:   c = '{0, 0, 0, -3, 27, 104};
      BC_T2:   c = '{0, 0, 0, 0, -11, 139};
      LZ_E0:   c = '{0, 0, 0, 144, -21, 5};
      LZ_E1:   c = '{0, 0, 103, 32, -8, 1};
      LZ_E2:   c = '{0, 0, 33, 107, -16, 4};
      LZ_E3:   c = '{0, -18, 118, 36, -9, 1};
      LZ_E4:   c = '{0, -9, 35, 115, -17, 4};
      LZ_M0:   c = '{4, -17, 114, 35, -9, 1};
      LZ_M1:   c = '{1, -9, 35, 114, -17, 4};
      LZ_T0:   c = '{0, 4, -17, 115, 35, -9};
      LZ_T1:   c = '{0, 1, -9, 36, 118, -18};
      LZ_T2:   c = '{0, 0, 4, -16, 107, 33};
      LZ_T3:   c = '{0, 0, 1, -8, 32, 103};
      LZ_T4:   c = '{0, 0, 0, 5, -21, 144};
      default: c = '{0, 0, 0, 0, 0, 0};
    endcase
    for (int i = 0; i < NumTaps; i++) begin
      row[i] = CoefW'(c[i]);
    end
    return row;
  endfunction

endpackage

/* sv/hcu_tap_cell.sv */
// One cell of the tap row: holds one sample, passes it to its older neighbor
// on each shift and registers the product with its coefficient. Uses hcu_pkg.
module hcu_tap_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              shift_en,
  input  logic [7:0]                        tap_in,
  input  hcu_pkg::coef_t                    coef,
  input  logic                              prod_en,
  output logic [7:0]                        tap_r,
  output logic signed [hcu_pkg::ProdW-1:0]  prod_r
);

  logic signed [hcu_pkg::ProdW-1:0] prod_nxt;

  assign prod_nxt = hcu_pkg::ProdW'($signed({1'b0, tap_r})) * hcu_pkg::ProdW'(coef);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= 8'd0;
    end else if (shift_en) begin
      tap_r <= tap_in;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

/* sv/hcu_burst_ctrl.sv */
// Burst control: counts samples of the line and, for each accepted item,
// steps through the output codes that item releases. Uses hcu_pkg.
module hcu_burst_ctrl #(
  parameter int MAX_WIDTH = hcu_pkg::MaxWidthDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_accept,
  input  logic                      adv,
  input  logic                      restart,
  input  logic                      kernel_mode,
  input  logic [hcu_pkg::LineW-1:0] line_width,
  output logic                      in_rdy,
  output hcu_pkg::seq_t             seq
);

  localparam int CntW = $clog2(MAX_WIDTH);

  logic [CntW-1:0]             cnt_r, cnt_nxt;
  logic [hcu_pkg::CodeW-1:0]   code_r, code_nxt;
  logic [hcu_pkg::RemW-1:0]    rem_r, rem_nxt;
  logic                        line_r, line_nxt;
  logic [CntW:0]               weff;
  logic                        last;
  logic [hcu_pkg::CodeW-1:0]   start;
  logic [hcu_pkg::RemW-1:0]    num;
  logic                        active;

  always_comb begin
    if (line_width < hcu_pkg::LINE_WIDTH_MIN) begin
      weff = (CntW+1)'(6);
    end else if (32'(line_width) > 32'(MAX_WIDTH)) begin
      weff = (CntW+1)'(MAX_WIDTH);
    end else begin
      weff = (CntW+1)'(line_width);
    end
  end

  assign last = (({1'b0, cnt_r} + (CntW+1)'(1)) >= weff);

  // The bursts of one mode use consecutive codes, so the tail of the last
  // sample simply continues after its middle pair.
  always_comb begin
    start = hcu_pkg::BC_E0;
    num   = 3'd0;
    if (!kernel_mode) begin
      if (cnt_r == CntW'(1)) begin
        start = hcu_pkg::BC_E0;
        num   = 3'd1;
      end else if (cnt_r == CntW'(2)) begin
        start = hcu_pkg::BC_E1;
        num   = 3'd2;
      end else if (cnt_r >= CntW'(3)) begin
        start = hcu_pkg::BC_M0;
        num   = last ? 3'd5 : 3'd2;
      end
    end else begin
      if (cnt_r == CntW'(2)) begin
        start = hcu_pkg::LZ_E0;
        num   = 3'd1;
      end else if (cnt_r == CntW'(3)) begin
        start = hcu_pkg::LZ_E1;
        num   = 3'd2;
      end else if (cnt_r == CntW'(4)) begin
        start = hcu_pkg::LZ_E3;
        num   = 3'd2;
      end else if (cnt_r >= CntW'(5)) begin
        start = hcu_pkg::LZ_M0;
        num   = last ? 3'd7 : 3'd2;
      end
    end
  end

  assign active = (rem_r != '0);
  assign in_rdy = !active || ((rem_r == 3'd1) && adv);

  always_comb begin
    cnt_nxt  = cnt_r;
    code_nxt = code_r;
    rem_nxt  = rem_r;
    line_nxt = line_r;
    if (in_accept) begin
      cnt_nxt  = last ? '0 : cnt_r + CntW'(1);
      code_nxt = start;
      rem_nxt  = num;
      line_nxt = last;
    end else if (active && adv) begin
      code_nxt = code_r + hcu_pkg::CodeW'(1);
      rem_nxt  = rem_r - 3'd1;
    end
    if (restart) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      rem_r  <= '0;
      code_r <= '0;
      line_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
      code_r <= code_nxt;
      line_r <= line_nxt;
    end
  end

  assign seq.active        = active;
  assign seq.code          = code_r;
  assign seq.last_of_burst = (rem_r == 3'd1);
  assign seq.line_done     = (rem_r == 3'd1) && line_r;

endmodule

/* sv/horizontal_2x_chroma_upsampler_top.sv */
// Top level of the horizontal 2x chroma upsampler: configuration registers,
// row of tap cells, burst control and the sum / round / clip output stage.
// Depends on hcu_pkg, hcu_tap_cell and hcu_burst_ctrl.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | in_sample
//  out_    | output    | out_valid / out_ready | out_pixel, out_last_of_burst, out_line_done
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_wdata
//
// One pixel leaves per cycle while the output is not stalled; a mid-line sample
// releases two pixels, the last of a line five (bicubic) or seven (Lanczos) with its tail.
// A pixel passes the product registers, then the registered sum / round / clip stage.
// Reset is synchronous and clears the taps, line position and registers; cfg_ready is always high.
// Output stalls freeze the products, the output and any active burst; a new item is
// taken while idle or in the cycle the previous one issues its final code unstalled.
module horizontal_2x_chroma_upsampler_top #(
  parameter int MAX_WIDTH = hcu_pkg::MaxWidthDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_pixel,
  output logic                        out_last_of_burst,
  output logic                        out_line_done,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hcu_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [hcu_pkg::LineW-1:0]   cfg_wdata
);

  logic                        mode_r;
  logic [hcu_pkg::LineW-1:0]   width_r;
  logic                        cfg_we;
  logic                        restart;
  logic                        in_accept;
  logic                        en;
  hcu_pkg::seq_t               seq;
  hcu_pkg::coef_row_t          row;
  logic [7:0]                  tap [hcu_pkg::NumTaps];
  logic signed [hcu_pkg::ProdW-1:0] prod [hcu_pkg::NumTaps];
  logic                        p_vld_r, p_lob_r, p_ld_r;
  logic signed [hcu_pkg::SumW-1:0]  sum;
  logic [7:0]                  pix;
  logic                        out_valid_r;
  logic [7:0]                  pixel_r;
  logic                        lob_r, ld_r;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign restart   = cfg_we && ((cfg_index == hcu_pkg::REG_KERNEL_MODE) ||
                                (cfg_index == hcu_pkg::REG_LINE_WIDTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      width_r <= hcu_pkg::LINE_WIDTH_RST;
    end else if (cfg_we) begin
      if (cfg_index == hcu_pkg::REG_KERNEL_MODE) begin
        mode_r <= cfg_wdata[0];
      end
      if (cfg_index == hcu_pkg::REG_LINE_WIDTH) begin
        width_r <= cfg_wdata;
      end
    end
  end

  assign en        = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  hcu_burst_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .adv         (en),
    .restart     (restart),
    .kernel_mode (mode_r),
    .line_width  (width_r),
    .in_rdy      (in_ready),
    .seq         (seq)
  );

  assign row = hcu_pkg::coef_row(seq.code);

  // Samples enter at the newest cell and move one cell toward the oldest
  // on each accepted item.
  for (genvar i = 0; i < hcu_pkg::NumTaps; i++) begin : g_cell
    logic [7:0] tin;
    if (i == hcu_pkg::NumTaps - 1) begin : g_head
      assign tin = in_sample;
    end else begin : g_link
      assign tin = tap[i+1];
    end
    hcu_tap_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_accept),
      .tap_in   (tin),
      .coef     (row[i]),
      .prod_en  (en),
      .tap_r    (tap[i]),
      .prod_r   (prod[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= seq.active;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_lob_r <= seq.last_of_burst;
      p_ld_r  <= seq.line_done;
    end
  end

  always_comb begin
    sum = hcu_pkg::SumW'(64);
    for (int i = 0; i < hcu_pkg::NumTaps; i++) begin
      sum = sum + hcu_pkg::SumW'(prod[i]);
    end
  end

  // Negative sums clip to zero; anything at or above 256 << 7 clips to 255.
  always_comb begin
    if (sum[hcu_pkg::SumW-1]) begin
      pix = 8'd0;
    end else if (|sum[hcu_pkg::SumW-2:15]) begin
      pix = 8'd255;
    end else begin
      pix = sum[14:7];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_r <= pix;
      lob_r   <= p_lob_r;
      ld_r    <= p_ld_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel         = pixel_r;
  assign out_last_of_burst = lob_r;
  assign out_line_done     = ld_r;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Testbench for horizontal_2x_chroma_upsampler_top: drives lines of samples and register
// writes, predicts every upsampled pixel and compares results in order.
// Depends on hcu_pkg and the upsampler RTL.
module testbench;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_LINE      = hcu_pkg::MaxWidthDef;
  localparam int MAX_PRINTS    = 40;

  localparam logic MODE_BICUBIC = 1'b0;
  localparam logic MODE_LANCZOS = 1'b1;

  // Register indexes with no register behind them.
  localparam logic [hcu_pkg::CfgIdxW-1:0] REG_RSVD2 = 2'd2;
  localparam logic [hcu_pkg::CfgIdxW-1:0] REG_RSVD3 = 2'd3;

  typedef enum int {
    BC_EDGE0, BC_EDGE1, BC_EDGE2, BC_MID0, BC_MID1, BC_TAIL0, BC_TAIL1, BC_TAIL2,
    LZ_EDGE0, LZ_EDGE1, LZ_EDGE2, LZ_EDGE3, LZ_EDGE4, LZ_MID0, LZ_MID1,
    LZ_TAIL0, LZ_TAIL1, LZ_TAIL2, LZ_TAIL3, LZ_TAIL4
  } kset_t;

  typedef enum int {STYLE_UNIFORM, STYLE_EXTREME, STYLE_FLAT} sample_style_t;

  // Kernel weights against the six newest samples, oldest first. Shortened
  // edge sets are padded with zeros on the old side.
  localparam int KTAPS [20][6] = '{
    '{0, 0, 0, 0, 139, -11},
    '{0, 0, 0, 104, 27, -3},
    '{0, 0, 0, 28, 109, -9},
    '{0, 0, -9, 111, 29, -3},
    '{0, 0, -3, 29, 111, -9},
    '{0, 0, 0, -9, 109, 28},
    '{0, 0, 0, -3, 27, 104},
    '{0, 0, 0, 0, -11, 139},
    '{0, 0, 0, 144, -21, 5},
    '{0, 0, 103, 32, -8, 1},
    '{0, 0, 33, 107, -16, 4},
    '{0, -18, 118, 36, -9, 1},
    '{0, -9, 35, 115, -17, 4},
    '{4, -17, 114, 35, -9, 1},
    '{1, -9, 35, 114, -17, 4},
    '{0, 4, -17, 115, 35, -9},
    '{0, 1, -9, 36, 118, -18},
    '{0, 0, 4, -16, 107, 33},
    '{0, 0, 1, -8, 32, 103},
    '{0, 0, 0, 5, -21, 144}
  };

  typedef struct packed {
    logic [7:0] pixel;
    logic       last_of_burst;
    logic       line_done;
  } upx_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [7:0]                  in_sample = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [7:0]                  out_pixel;
  logic                        out_last_of_burst;
  logic                        out_line_done;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [hcu_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [hcu_pkg::LineW-1:0]   cfg_wdata = '0;

  // Predictor state.
  logic [7:0]               taps [6];
  int                       line_pos;
  logic                     mode_bit;
  logic [hcu_pkg::LineW-1:0] width_raw;
  upx_t                     pending_px [$];

  int  mismatches   = 0;
  int  pixels_seen  = 0;
  int  samples_sent = 0;
  int  cycles       = 0;
  int  stall_left   = 0;
  bit  idle_on      = 1'b1;

  horizontal_2x_chroma_upsampler_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel         (out_pixel),
    .out_last_of_burst (out_last_of_burst),
    .out_line_done     (out_line_done),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side stalls in bursts of random length, started only while idle_on is set.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int eff_width(input logic [hcu_pkg::LineW-1:0] raw);
    int w;
    w = int'(raw);
    if (w < int'(hcu_pkg::LINE_WIDTH_MIN)) w = int'(hcu_pkg::LINE_WIDTH_MIN);
    if (w > MAX_LINE) w = MAX_LINE;
    return w;
  endfunction

  function automatic logic [7:0] interp(input kset_t ks);
    int acc;
    int i;
    acc = 64;
    for (i = 0; i < 6; i++) begin
      acc += int'(taps[i]) * KTAPS[ks][i];
    end
    if (acc < 0) return 8'd0;
    acc = acc >>> 7;
    if (acc > 255) return 8'd255;
    return acc[7:0];
  endfunction

  task automatic apply_cfg(input logic [hcu_pkg::CfgIdxW-1:0] idx,
                           input logic [hcu_pkg::LineW-1:0] val);
    if (idx == hcu_pkg::REG_KERNEL_MODE) begin
      mode_bit = val[0];
      line_pos = 0;
    end else if (idx == hcu_pkg::REG_LINE_WIDTH) begin
      width_raw = val;
      line_pos  = 0;
    end
  endtask

  // Shifts one sample into the window and queues the pixels it releases.
  task automatic predict_upsample(input logic [7:0] s);
    int    w;
    int    k;
    int    n;
    int    i;
    bit    last;
    kset_t sets [7];
    w = eff_width(width_raw);
    for (i = 0; i < 5; i++) begin
      taps[i] = taps[i + 1];
    end
    taps[5] = s;
    k = line_pos;
    last = (k + 1 >= w);
    n = 0;
    if (mode_bit == MODE_BICUBIC) begin
      if (k == 1) begin
        sets[0] = BC_EDGE0;
        n = 1;
      end else if (k == 2) begin
        sets[0] = BC_EDGE1;
        sets[1] = BC_EDGE2;
        n = 2;
      end else if (k >= 3) begin
        sets[0] = BC_MID0;
        sets[1] = BC_MID1;
        n = 2;
      end
      if (last) begin
        sets[n]     = BC_TAIL0;
        sets[n + 1] = BC_TAIL1;
        sets[n + 2] = BC_TAIL2;
        n += 3;
      end
    end else begin
      if (k == 2) begin
        sets[0] = LZ_EDGE0;
        n = 1;
      end else if (k == 3) begin
        sets[0] = LZ_EDGE1;
        sets[1] = LZ_EDGE2;
        n = 2;
      end else if (k == 4) begin
        sets[0] = LZ_EDGE3;
        sets[1] = LZ_EDGE4;
        n = 2;
      end else if (k >= 5) begin
        sets[0] = LZ_MID0;
        sets[1] = LZ_MID1;
        n = 2;
      end
      if (last) begin
        sets[n]     = LZ_TAIL0;
        sets[n + 1] = LZ_TAIL1;
        sets[n + 2] = LZ_TAIL2;
        sets[n + 3] = LZ_TAIL3;
        sets[n + 4] = LZ_TAIL4;
        n += 5;
      end
    end
    for (i = 0; i < n; i++) begin
      pending_px.push_back(upx_t'{interp(sets[i]), i == n - 1, last && (i == n - 1)});
    end
    line_pos = last ? 0 : k + 1;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("[%0t] %s mismatch at pixel %0d: got %0d, expected %0d",
               $time, what, pixels_seen, got, want);
    end
  endtask

  task automatic check_pixel();
    upx_t want;
    if (pending_px.size() == 0) begin
      report_mismatch("unexpected pixel", int'(out_pixel), -1);
    end else begin
      want = pending_px.pop_front();
      if (out_pixel != want.pixel)
        report_mismatch("pixel", int'(out_pixel), int'(want.pixel));
      if (out_last_of_burst != want.last_of_burst)
        report_mismatch("last_of_burst", int'(out_last_of_burst), int'(want.last_of_burst));
      if (out_line_done != want.line_done)
        report_mismatch("line_done", int'(out_line_done), int'(want.line_done));
    end
    pixels_seen++;
  endtask

  // Every handshake is taken from the values present at the clock edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      taps       = '{default: 8'd0};
      line_pos   = 0;
      mode_bit   = MODE_BICUBIC;
      width_raw  = hcu_pkg::LINE_WIDTH_RST;
    end else begin
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_wdata);
      if (in_valid && in_ready) predict_upsample(in_sample);
      if (out_valid && out_ready) check_pixel();
    end
  end

  task automatic send_sample(input logic [7:0] s);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // Drops in_valid and lets every queued pixel leave, then idles for the settle
  // period so the pipe can empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [hcu_pkg::CfgIdxW-1:0] idx,
                           input logic [hcu_pkg::LineW-1:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_sample(input sample_style_t style, input logic [7:0] base);
    case (style)
      STYLE_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      STYLE_FLAT:    return base ^ 8'($urandom_range(0, 3));
      default:       return 8'($urandom);
    endcase
  endfunction

  // Reset settings: bicubic, eight samples per line, hard edges to force clipping.
  task automatic test_reset_state();
    logic [7:0] line [8];
    int         i;
    line = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00};
    for (i = 0; i < 8; i++) send_sample(line[i]);
  endtask

  // Lanczos with the narrowest line; the mode write carries junk above bit 0
  // and the width write is below the minimum.
  task automatic test_lanczos_narrow();
    int i;
    write_reg(hcu_pkg::REG_KERNEL_MODE, {12'hFFF, MODE_LANCZOS});
    write_reg(hcu_pkg::REG_LINE_WIDTH, 13'd5);
    for (i = 0; i < 6; i++) send_sample((i % 2 == 0) ? 8'hFF : 8'h00);
  endtask

  // A write to an unused index keeps the line going; a real write restarts it.
  task automatic test_register_rules();
    int i;
    write_reg(hcu_pkg::REG_KERNEL_MODE, {12'h001, MODE_BICUBIC});
    write_reg(hcu_pkg::REG_LINE_WIDTH, 13'd0);
    for (i = 0; i < 3; i++) send_sample(8'(8'h40 * i + 8'h11));
    write_reg(REG_RSVD2, 13'h1FFF);
    for (i = 0; i < 3; i++) send_sample(8'hFF);
    for (i = 0; i < 2; i++) send_sample(8'h80);
    write_reg(hcu_pkg::REG_KERNEL_MODE, {12'h000, MODE_LANCZOS});
    write_reg(REG_RSVD3, 13'h0000);
    for (i = 0; i < 6; i++) send_sample(8'(8'hF0 - 8'h30 * i));
  endtask

  task automatic test_random_lines();
    int                        goal;
    int                        pick;
    int                        w;
    int                        lines;
    int                        extra;
    int                        j;
    logic [hcu_pkg::LineW-1:0] wraw;
    sample_style_t             style;
    logic [7:0]                base;
    goal = samples_sent + 55;
    while (samples_sent < goal) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) != 0) write_reg(hcu_pkg::REG_KERNEL_MODE, 13'($urandom));
      pick = $urandom_range(0, 9);
      if (pick < 7) wraw = 13'($urandom_range(6, 14));
      else if (pick == 7) wraw = 13'($urandom_range(0, 5));
      else if (pick == 8) wraw = 13'($urandom_range(15, 40));
      else wraw = $urandom_range(0, 1) ? 13'(MAX_LINE) : 13'($urandom_range(MAX_LINE + 1, 8191));
      write_reg(hcu_pkg::REG_LINE_WIDTH, wraw);
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? REG_RSVD2 : REG_RSVD3, 13'($urandom));
      w = eff_width(wraw);
      // Wide lines are only started here and cut short by the next write.
      if (w > 40) begin
        lines = 0;
        extra = $urandom_range(1, 12);
      end else begin
        lines = (w > 14) ? 1 : $urandom_range(1, 3);
        extra = $urandom_range(0, 2) == 0 ? $urandom_range(1, w - 1) : 0;
      end
      style = sample_style_t'($urandom_range(0, 2));
      base  = 8'($urandom);
      for (j = 0; j < lines * w + extra; j++) send_sample(pick_sample(style, base));
    end
  endtask

  // Back-to-back traffic with no idling, a few full lines in each mode.
  task automatic test_steady_stream();
    int j;
    idle_on = 1'b0;
    write_reg(hcu_pkg::REG_KERNEL_MODE, {12'h000, MODE_BICUBIC});
    write_reg(hcu_pkg::REG_LINE_WIDTH, 13'd7);
    for (j = 0; j < 21; j++) send_sample(8'($urandom));
    write_reg(hcu_pkg::REG_KERNEL_MODE, {12'h000, MODE_LANCZOS});
    write_reg(hcu_pkg::REG_LINE_WIDTH, 13'd9);
    for (j = 0; j < 18; j++) send_sample(8'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_lanczos_narrow();
    test_register_rules();
    test_random_lines();
    test_steady_stream();
    wait_drained();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
